// ===== design/snapid_pkg.sv =====
// Shared types, constants and helper functions of the single-neuron adaptive PID core.
// Used by snapid_ctrl, snapid_dp and the top level; depends on nothing else.
package snapid_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DW            = 32;
  localparam int UW            = 31;
  localparam int PCTW          = 23;
  localparam int RIDXW         = 3;
  localparam int SATW          = 70;

  localparam logic [RIDXW-1:0] REG_SETPOINT   = 3'd0;
  localparam logic [RIDXW-1:0] REG_DEAD_BAND  = 3'd1;
  localparam logic [RIDXW-1:0] REG_STEP_GAIN  = 3'd2;
  localparam logic [RIDXW-1:0] REG_RATE_PROP  = 3'd3;
  localparam logic [RIDXW-1:0] REG_RATE_INTEG = 3'd4;
  localparam logic [RIDXW-1:0] REG_RATE_DERIV = 3'd5;
  localparam logic [RIDXW-1:0] REG_OUT_UPPER  = 3'd6;
  localparam logic [RIDXW-1:0] REG_OUT_LOWER  = 3'd7;

  localparam logic signed [DW-1:0] SETPOINT_RST  = 32'sd0;
  localparam logic [UW-1:0]        DEAD_BAND_RST = 31'd0;
  localparam logic [UW-1:0]        STEP_GAIN_RST = 31'd2621;
  localparam logic [UW-1:0]        RATE_PROP_RST = 31'd26214;
  localparam logic [UW-1:0]        RATE_INTEG_RST = 31'd22938;
  localparam logic [UW-1:0]        RATE_DERIV_RST = 31'd26214;
  localparam logic signed [DW-1:0] OUT_UPPER_RST = 32'sd65536000;
  localparam logic signed [DW-1:0] OUT_LOWER_RST = 32'sd0;

  // Term and weight slots: the error, its first and its second difference.
  localparam logic [1:0] K_INTEG = 2'd0;
  localparam logic [1:0] K_PROP  = 2'd1;
  localparam logic [1:0] K_DERIV = 2'd2;

  // Operand pairs of the three learning products.
  localparam logic [1:0] LM_RATE = 2'd0;
  localparam logic [1:0] LM_RES  = 2'd1;
  localparam logic [1:0] LM_TERM = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_TERMS,
    OP_DIVW,
    OP_DIVP,
    OP_DSTEP,
    OP_NORM,
    OP_MULNX,
    OP_ACC,
    OP_ASAT,
    OP_GMUL,
    OP_DELTA,
    OP_RES,
    OP_PCT,
    OP_LMUL,
    OP_LSAT
  } op_e;

  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_WUPD,
    FIN_OUT
  } fin_e;

  typedef struct packed {
    op_e        op;
    fin_e       fin;
    logic [1:0] idx;
    logic [1:0] stage;
  } cmd_t;

  typedef struct packed {
    logic in_band;
    logic sum_zero;
    logic span_pos;
    logic out_free;
  } sts_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [SATW-1:0] v);
    logic signed [DW-1:0] r;
    if (!v[SATW-1] && (|v[SATW-2:DW-1])) begin
      r = {1'b0, {(DW-1){1'b1}}};
    end else if (v[SATW-1] && !(&v[SATW-2:DW-1])) begin
      r = {1'b1, {(DW-1){1'b0}}};
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] mag32(input logic signed [DW-1:0] v);
    logic [DW-1:0] r;
    r = v[DW-1] ? DW'(-v) : DW'(v);
    return r;
  endfunction

endpackage

// ===== design/snapid_ctrl.sv =====
// Sequencer of the single-neuron adaptive PID core: steps the datapath through one tick.
// Depends on snapid_pkg for the command and status types.
module snapid_ctrl import snapid_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam int CW = $clog2(FRAC_BITS + 8);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TERMS = 4'd1;
  localparam logic [3:0] S_DLOAD = 4'd2;
  localparam logic [3:0] S_DSTEP = 4'd3;
  localparam logic [3:0] S_NORM  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd6;
  localparam logic [3:0] S_ASAT  = 4'd7;
  localparam logic [3:0] S_GMUL  = 4'd8;
  localparam logic [3:0] S_DELTA = 4'd9;
  localparam logic [3:0] S_RES   = 4'd10;
  localparam logic [3:0] S_PLOAD = 4'd11;
  localparam logic [3:0] S_PCT   = 4'd12;
  localparam logic [3:0] S_LMUL  = 4'd13;
  localparam logic [3:0] S_LSAT  = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    k_q, k_d;
  logic [1:0]    m_q, m_d;
  logic          ph_q, ph_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    m_d     = m_q;
    ph_d    = ph_q;
    cmd_o   = '{op: OP_NONE, fin: FIN_NONE, idx: k_q, stage: m_q};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_TERMS;
        end
      end
      S_TERMS: begin
        cmd_o.op = OP_TERMS;
        k_d      = K_INTEG;
        if (sts_i.in_band || sts_i.sum_zero) begin
          state_d = S_RES;
        end else begin
          state_d = S_DLOAD;
        end
      end
      S_DLOAD: begin
        cmd_o.op = OP_DIVW;
        cnt_d    = CW'(FRAC_BITS + 1);
        ph_d     = 1'b0;
        state_d  = S_DSTEP;
      end
      S_DSTEP: begin
        cmd_o.op = OP_DSTEP;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          state_d = ph_q ? S_PCT : S_NORM;
        end
      end
      S_NORM: begin
        cmd_o.op = OP_NORM;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = OP_MULNX;
        state_d  = S_ACC;
      end
      S_ACC: begin
        cmd_o.op = OP_ACC;
        if (k_q == K_DERIV) begin
          state_d = S_ASAT;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_DLOAD;
        end
      end
      S_ASAT: begin
        cmd_o.op = OP_ASAT;
        state_d  = S_GMUL;
      end
      S_GMUL: begin
        cmd_o.op = OP_GMUL;
        state_d  = S_DELTA;
      end
      S_DELTA: begin
        cmd_o.op = OP_DELTA;
        state_d  = S_RES;
      end
      S_RES: begin
        cmd_o.op = OP_RES;
        k_d      = K_INTEG;
        m_d      = LM_RATE;
        state_d  = sts_i.span_pos ? S_PLOAD : S_LMUL;
      end
      S_PLOAD: begin
        cmd_o.op = OP_DIVP;
        cnt_d    = CW'(FRAC_BITS + 7);
        ph_d     = 1'b1;
        state_d  = S_DSTEP;
      end
      S_PCT: begin
        cmd_o.op = OP_PCT;
        k_d      = K_INTEG;
        m_d      = LM_RATE;
        state_d  = S_LMUL;
      end
      S_LMUL: begin
        cmd_o.op = OP_LMUL;
        state_d  = S_LSAT;
      end
      S_LSAT: begin
        cmd_o.op = OP_LSAT;
        if (m_q == LM_TERM) begin
          cmd_o.fin = FIN_WUPD;
          m_d       = LM_RATE;
          if (k_q == K_DERIV) begin
            state_d = S_OUT;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_LMUL;
          end
        end else begin
          m_d     = m_q + 1'b1;
          state_d = S_LMUL;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.fin = FIN_OUT;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      k_q     <= K_INTEG;
      m_q     <= LM_RATE;
      ph_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      m_q     <= m_d;
      ph_q    <= ph_d;
    end
  end

endmodule

// ===== design/snapid_dp.sv =====
// Datapath of the single-neuron adaptive PID core: registers, one shared multiplier and
// a shift-subtract divider, driven by commands from snapid_ctrl. Depends on snapid_pkg.
module snapid_dp import snapid_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [RIDXW-1:0]       cfg_idx_i,
  input  logic [DW-1:0]          cfg_wdata_i,
  input  logic signed [DW-1:0]   measured_i,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [DW-1:0]   drive_o,
  output logic [PCTW-1:0]        drive_percent_o,
  output logic                   in_dead_band_o,
  output logic                   div_fault_o
);

  localparam int KMAX = FRAC_BITS + 7;
  localparam int NWW  = FRAC_BITS + 2;
  localparam int MW   = DW + 1;
  localparam int PW   = 2 * MW;
  localparam int ACCW = PW + 2;
  localparam int DELW = 63 - FRAC_BITS;
  localparam int SW   = DELW + 1;
  localparam int RW   = DW + 1;
  localparam logic signed [DW-1:0] WEIGHT_INIT = DW'(((1 << FRAC_BITS) + 5) / 10);

  logic signed [DW-1:0]   setpoint_q, out_upper_q, out_lower_q;
  logic [UW-1:0]          dead_band_q, step_gain_q, rate_prop_q, rate_integ_q, rate_deriv_q;
  logic signed [DW-1:0]   w_q [3];
  logic signed [DW-1:0]   el_q, ebl_q, held_q;
  logic                   out_valid_q;

  logic signed [DW-1:0]   err_q, res_q, p_q;
  logic signed [DW-1:0]   x_q [3];
  logic signed [NWW-1:0]  nw_q [3];
  logic signed [ACCW-1:0] acc_q;
  logic signed [PW-1:0]   prod_q;
  logic signed [DELW-1:0] delta_q;
  logic [RW-1:0]          rem_q, den_q;
  logic [KMAX-1:0]        sh_q;
  logic [PCTW-1:0]        pct_q;
  logic                   inside_q, fault_q;
  logic signed [DW-1:0]   drive_q;
  logic [PCTW-1:0]        pct_o_q;
  logic                   inside_o_q, fault_o_q;

  logic signed [DW-1:0]   err_d, d1, d2, w_sel, x_sel, res_d;
  logic signed [NWW-1:0]  nw_sel;
  logic [UW-1:0]          rate_sel;
  logic [RW-1:0]          sum_w;
  logic signed [RW-1:0]   span;
  logic                   in_band, span_zero;
  logic signed [MW-1:0]   ma, mb;
  logic signed [PW-1:0]   mprod;
  logic [RW:0]            trial;
  logic                   ge;
  logic [DW-1:0]          wm, num;
  logic [RW-1:0]          numw;
  logic [38:0]            p100;
  logic signed [SW-1:0]   rsum, rclip, up_x, lo_x;

  assign w_sel  = w_q[cmd_i.idx];
  assign x_sel  = x_q[cmd_i.idx];
  assign nw_sel = nw_q[cmd_i.idx];

  always_comb begin
    case (cmd_i.idx)
      K_INTEG: rate_sel = rate_integ_q;
      K_PROP:  rate_sel = rate_prop_q;
      default: rate_sel = rate_deriv_q;
    endcase
  end

  assign err_d = sat32(SATW'(setpoint_q) - SATW'(measured_i));
  assign d1    = sat32(SATW'(err_q) - SATW'(el_q));
  assign d2    = sat32(SATW'(err_q) - SATW'(el_q) - SATW'(el_q) + SATW'(ebl_q));
  assign sum_w = RW'(mag32(w_q[0])) + RW'(mag32(w_q[1])) + RW'(mag32(w_q[2]));
  assign in_band = (mag32(err_q) <= DW'(dead_band_q));
  assign span  = RW'(out_upper_q) - RW'(out_lower_q);
  assign span_zero = (span == '0);

  assign sts_o.in_band  = in_band;
  assign sts_o.sum_zero = (sum_w == '0);
  assign sts_o.span_pos = !span[RW-1] && !span_zero;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_MULNX: begin
        ma = MW'(nw_sel);
        mb = MW'(x_sel);
      end
      OP_GMUL: begin
        ma = MW'(p_q);
        mb = MW'(step_gain_q);
      end
      OP_LMUL: begin
        case (cmd_i.stage)
          LM_RATE: begin
            ma = MW'(rate_sel);
            mb = MW'(err_q);
          end
          LM_RES: begin
            ma = MW'(p_q);
            mb = MW'(res_q);
          end
          default: begin
            ma = MW'(p_q);
            mb = MW'(x_sel);
          end
        endcase
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mprod = ma * mb;

  assign trial = {rem_q, sh_q[KMAX-1]};
  assign ge    = (trial >= {1'b0, den_q});
  assign wm    = mag32(w_sel);
  assign numw  = RW'(res_q) - RW'(out_lower_q);
  assign num   = numw[DW-1:0];
  assign p100  = 39'(num) * 39'(100);

  assign up_x  = SW'(out_upper_q);
  assign lo_x  = SW'(out_lower_q);
  assign rsum  = SW'(held_q) + SW'(delta_q);
  assign rclip = (rsum > up_x) ? up_x : rsum;
  assign res_d = (rclip < lo_x) ? out_lower_q : rclip[DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q   <= SETPOINT_RST;
      dead_band_q  <= DEAD_BAND_RST;
      step_gain_q  <= STEP_GAIN_RST;
      rate_prop_q  <= RATE_PROP_RST;
      rate_integ_q <= RATE_INTEG_RST;
      rate_deriv_q <= RATE_DERIV_RST;
      out_upper_q  <= OUT_UPPER_RST;
      out_lower_q  <= OUT_LOWER_RST;
      w_q[0]       <= WEIGHT_INIT;
      w_q[1]       <= WEIGHT_INIT;
      w_q[2]       <= WEIGHT_INIT;
      el_q         <= '0;
      ebl_q        <= '0;
      held_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SETPOINT:   setpoint_q   <= cfg_wdata_i;
          REG_DEAD_BAND:  dead_band_q  <= cfg_wdata_i[UW-1:0];
          REG_STEP_GAIN:  step_gain_q  <= cfg_wdata_i[UW-1:0];
          REG_RATE_PROP:  rate_prop_q  <= cfg_wdata_i[UW-1:0];
          REG_RATE_INTEG: rate_integ_q <= cfg_wdata_i[UW-1:0];
          REG_RATE_DERIV: rate_deriv_q <= cfg_wdata_i[UW-1:0];
          REG_OUT_UPPER:  out_upper_q  <= cfg_wdata_i;
          REG_OUT_LOWER:  out_lower_q  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.op == OP_RES) begin
        held_q <= res_d;
      end
      if (cmd_i.fin == FIN_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.fin)
        FIN_WUPD: begin
          w_q[cmd_i.idx] <= sat32(SATW'(w_sel) + SATW'(sat32(SATW'(prod_q >>> FRAC_BITS))));
        end
        FIN_OUT: begin
          el_q        <= err_q;
          ebl_q       <= el_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        err_q <= err_d;
      end
      OP_TERMS: begin
        x_q[K_INTEG] <= err_q;
        x_q[K_PROP]  <= d1;
        x_q[K_DERIV] <= d2;
        inside_q     <= in_band;
        fault_q      <= !in_band && (sum_w == '0);
        acc_q        <= '0;
        delta_q      <= '0;
      end
      OP_DIVW: begin
        rem_q <= RW'(wm >> 1);
        sh_q  <= {wm[0], (KMAX-1)'(0)};
        den_q <= sum_w;
      end
      OP_DIVP: begin
        rem_q <= RW'(p100 >> 7);
        sh_q  <= {p100[6:0], FRAC_BITS'(0)};
        den_q <= span;
      end
      OP_DSTEP: begin
        rem_q <= ge ? RW'(trial - {1'b0, den_q}) : RW'(trial);
        sh_q  <= {sh_q[KMAX-2:0], ge};
      end
      OP_NORM: begin
        nw_q[cmd_i.idx] <= w_sel[DW-1] ? -NWW'(sh_q[FRAC_BITS:0])
                                       : NWW'(sh_q[FRAC_BITS:0]);
      end
      OP_MULNX, OP_GMUL, OP_LMUL: begin
        prod_q <= mprod;
      end
      OP_ACC: begin
        acc_q <= acc_q + ACCW'(prod_q);
      end
      OP_ASAT: begin
        p_q <= sat32(SATW'(acc_q >>> FRAC_BITS));
      end
      OP_DELTA: begin
        delta_q <= DELW'(prod_q >>> FRAC_BITS);
      end
      OP_RES: begin
        res_q   <= res_d;
        pct_q   <= '0;
        fault_q <= fault_q || span_zero;
      end
      OP_PCT: begin
        pct_q <= PCTW'(sh_q);
      end
      OP_LSAT: begin
        p_q <= sat32(SATW'(prod_q >>> FRAC_BITS));
      end
      default: begin
      end
    endcase
    if (cmd_i.fin == FIN_OUT) begin
      drive_q    <= res_q;
      pct_o_q    <= pct_q;
      inside_o_q <= inside_q;
      fault_o_q  <= fault_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_o         = drive_q;
  assign drive_percent_o = pct_o_q;
  assign in_dead_band_o  = inside_o_q;
  assign div_fault_o     = fault_o_q;

endmodule

// ===== design/single_neuron_adaptive_pid_core.sv =====
// Top level of the single-neuron adaptive PID core: joins sequencer and datapath.
// Depends on snapid_pkg, snapid_ctrl and snapid_dp.
//
// One measurement enters on the in channel (valid/ready) per control tick; one result
// (drive, drive percentage, deadband and division-fault flags) leaves on the out channel.
// Settings must be written through the plain write port only while the core is idle; the
// core itself does not enforce this. Inside the deadband or with all weights zero the three
// weight divisions are skipped, and a zero or inverted clamp range skips the percentage
// division. The core works on one item at a time; the time is set by the shared
// shift-subtract divider (one quotient bit per cycle for the three weight normalisations
// and the percentage) and by the single shared multiplier that forms the weighted sum,
// the gain product and nine learning products in turn. in_ready_o is high only while no
// item is being worked on.
// The result stays in an output register, so the next item is accepted while it waits;
// if the receiver still stalls when the next result is done, the core holds that result
// back until the output register is free.
// Reset loads the default settings, weights of one tenth and zero error history.
module single_neuron_adaptive_pid_core import snapid_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [RIDXW-1:0]     cfg_idx_i,
  input  logic [DW-1:0]        cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [DW-1:0] measured_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [DW-1:0] drive_o,
  output logic [PCTW-1:0]      drive_percent_o,
  output logic                 in_dead_band_o,
  output logic                 div_fault_o
);

  cmd_t cmd;
  sts_t sts;

  snapid_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  snapid_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .measured_i      (measured_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_o         (drive_o),
    .drive_percent_o (drive_percent_o),
    .in_dead_band_o  (in_dead_band_o),
    .div_fault_o     (div_fault_o)
  );

endmodule

// ===== verif/single_neuron_adaptive_pid_core_checker.sv =====
// Checker for the single-neuron adaptive PID core: mirrors the settings written, predicts
// each result from the accepted measurements and compares it with what the core shows.
// Depends on snapid_pkg only.
module single_neuron_adaptive_pid_core_checker import snapid_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [RIDXW-1:0]     cfg_idx_i,
  input  logic [DW-1:0]        cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic signed [DW-1:0] measured_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic signed [DW-1:0] drive_i,
  input  logic [PCTW-1:0]      drive_percent_i,
  input  logic                 in_dead_band_i,
  input  logic                 div_fault_i,
  output int                   fail_count_o,
  output int                   awaited_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint W_INIT = ((64'sd1 <<< FB) + 5) / 10;

  typedef struct {
    logic signed [DW-1:0] drive;
    logic [PCTW-1:0]      percent;
    logic                 dead;
    logic                 fault;
  } drive_t;

  drive_t drive_q[$];
  longint sp, db, gain, r_prop, r_integ, r_deriv, upper, lower;
  longint w_prop, w_integ, w_deriv, e_last, e_prev, held;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> FB;
  endfunction

  function automatic longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint normalise(longint w, longint sum);
    longint q;
    q = (absv(w) <<< FB) / sum;
    return w < 0 ? -q : q;
  endfunction

  function automatic longint hebb(longint w, longint rate, longint e, longint r, longint x);
    longint p;
    p = clip32(qmul(rate, e));
    p = clip32(qmul(p, r));
    p = clip32(qmul(p, x));
    return clip32(w + p);
  endfunction

  task automatic predict_drive(input longint meas);
    longint e, x1, x2, delta, sum, acc, r, span;
    longint unsigned pct;
    drive_t d;
    e = clip32(sp - meas);
    x1 = clip32(e - e_last);
    x2 = clip32(e - 2 * e_last + e_prev);
    d.dead = absv(e) <= db;
    d.fault = 1'b0;
    delta = 0;
    pct = 0;
    if (!d.dead) begin
      sum = absv(w_integ) + absv(w_prop) + absv(w_deriv);
      if (sum == 0) begin
        d.fault = 1'b1;
      end else begin
        acc = (normalise(w_integ, sum) * e + normalise(w_prop, sum) * x1
               + normalise(w_deriv, sum) * x2) >>> FB;
        delta = qmul(clip32(acc), gain);
      end
    end
    r = held + delta;
    if (r > upper) r = upper;
    if (r < lower) r = lower;
    held = r;
    span = upper - lower;
    if (span == 0) begin
      d.fault = 1'b1;
    end else if (span > 0) begin
      pct = ((longint'(r - lower) * 100) <<< FB) / span;
    end
    w_integ = hebb(w_integ, r_integ, e, r, e);
    w_prop = hebb(w_prop, r_prop, e, r, x1);
    w_deriv = hebb(w_deriv, r_deriv, e, r, x2);
    e_prev = e_last;
    e_last = e;
    d.drive = r[DW-1:0];
    d.percent = pct[PCTW-1:0];
    drive_q.push_back(d);
  endtask

  assign awaited_o = drive_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp = 0; db = 0; gain = 2621; r_prop = 26214; r_integ = 22938; r_deriv = 26214;
      upper = 65536000; lower = 0;
      w_prop = W_INIT; w_integ = W_INIT; w_deriv = W_INIT;
      e_last = 0; e_prev = 0; held = 0;
      drive_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SETPOINT:   sp = longint'(signed'(cfg_wdata_i));
          REG_DEAD_BAND:  db = longint'(cfg_wdata_i[UW-1:0]);
          REG_STEP_GAIN:  gain = longint'(cfg_wdata_i[UW-1:0]);
          REG_RATE_PROP:  r_prop = longint'(cfg_wdata_i[UW-1:0]);
          REG_RATE_INTEG: r_integ = longint'(cfg_wdata_i[UW-1:0]);
          REG_RATE_DERIV: r_deriv = longint'(cfg_wdata_i[UW-1:0]);
          REG_OUT_UPPER:  upper = longint'(signed'(cfg_wdata_i));
          REG_OUT_LOWER:  lower = longint'(signed'(cfg_wdata_i));
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (drive_q.size() == 0) begin
          $error("unexpected result: drive %0d", drive_i);
          fail_count_o++;
        end else begin
          drive_t d;
          d = drive_q.pop_front();
          if (drive_i !== d.drive) begin
            $error("drive: expected %0d, got %0d", d.drive, drive_i);
            fail_count_o++;
          end
          if (drive_percent_i !== d.percent) begin
            $error("drive_percent: expected %0d, got %0d", d.percent, drive_percent_i);
            fail_count_o++;
          end
          if (in_dead_band_i !== d.dead) begin
            $error("in_dead_band: expected %0b, got %0b", d.dead, in_dead_band_i);
            fail_count_o++;
          end
          if (div_fault_i !== d.fault) begin
            $error("div_fault: expected %0b, got %0b", d.fault, div_fault_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_drive(longint'(measured_i));
    end
  end
endmodule

// ===== verif/single_neuron_adaptive_pid_core_test.sv =====
// Testbench top of the single-neuron adaptive PID core: clock, reset, settings, measurement
// stimulus and receiver stalls; the checker beside the core judges every result.
// Depends on snapid_pkg, single_neuron_adaptive_pid_core and its checker.
module single_neuron_adaptive_pid_core_test;
  import snapid_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [RIDXW-1:0]     cfg_idx_i = '0;
  logic [DW-1:0]        cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic signed [DW-1:0] measured_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [DW-1:0] drive_o;
  logic [PCTW-1:0]      drive_percent_o;
  logic                 in_dead_band_o;
  logic                 div_fault_o;
  int                   fail_count;
  int                   awaited;
  int                   idle_mode = 0;
  int                   quiet_cycles = 0;
  bit                   hold_req = 1'b0;
  int                   hold_left = 0;
  logic signed [DW-1:0] target = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  single_neuron_adaptive_pid_core dut (.*);

  single_neuron_adaptive_pid_core_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .measured_i,
    .out_valid_i(out_valid_o), .out_ready_i, .drive_i(drive_o),
    .drive_percent_i(drive_percent_o), .in_dead_band_i(in_dead_band_o),
    .div_fault_i(div_fault_o), .fail_count_o(fail_count), .awaited_o(awaited)
  );

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= 400;
      out_ready_i <= 1'b0;
    end else begin
      case (idle_mode)
        0: out_ready_i <= $urandom_range(99) >= 54;
        1: out_ready_i <= $urandom_range(99) >= 38;
        default: out_ready_i <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles > 20000) begin
      $display("single_neuron_adaptive_pid_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [RIDXW-1:0] idx, input logic [DW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    if (idx == REG_SETPOINT) target = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (awaited != 0) @(posedge clk_i);
  endtask

  task automatic send_measure(input logic signed [DW-1:0] value);
    int gap;
    gap = 0;
    if (idle_mode == 0) begin
      while ($urandom_range(99) < 38) gap++;
    end else if (idle_mode == 1) begin
      while ($urandom_range(99) < 54) gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    measured_i <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic settle_and_pause();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    drain();
  endtask

  function automatic logic signed [DW-1:0] pick_measure();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 2) return $urandom;
    if (sel < 4) return target + $signed(32'($urandom_range(131072))) - 65536;
    return target + $signed(32'($urandom_range(2000000))) - 1000000;
  endfunction

  initial begin
    logic [DW-1:0] directed[$];
    int phase;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0001_0000,
                 32'hfff0_0000, 32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff,
                 32'h1234_5678, 32'hedcb_a988, 32'h0};
    foreach (directed[i]) send_measure(directed[i]);
    settle_and_pause();
    write_reg(REG_DEAD_BAND, 32'h7fff_ffff);
    foreach (directed[i]) if (i < 4) send_measure(directed[i]);
    settle_and_pause();
    write_reg(REG_DEAD_BAND, 32'd0);
    write_reg(REG_OUT_UPPER, 32'd4096);
    write_reg(REG_OUT_LOWER, 32'd4096);
    send_measure(32'hffff_0000);
    send_measure(32'h0001_0000);
    settle_and_pause();
    write_reg(REG_OUT_UPPER, 32'hffff_0000);
    write_reg(REG_OUT_LOWER, 32'h0001_0000);
    send_measure(32'hffff_0000);
    send_measure(32'h0010_0000);
    settle_and_pause();

    for (phase = 0; phase < 10; phase++) begin
      if (phase == 3) idle_mode = 1;
      if (phase == 6) idle_mode = 2;
      case (phase)
        0: begin
          write_reg(REG_SETPOINT, 32'h0010_0000);
          write_reg(REG_DEAD_BAND, 32'd0);
          write_reg(REG_STEP_GAIN, 32'd2621);
          write_reg(REG_RATE_PROP, 32'd26214);
          write_reg(REG_RATE_INTEG, 32'd22938);
          write_reg(REG_RATE_DERIV, 32'd26214);
          write_reg(REG_OUT_UPPER, 32'd65536000);
          write_reg(REG_OUT_LOWER, 32'd0);
        end
        1: begin
          write_reg(REG_SETPOINT, 32'h7fff_ffff);
          write_reg(REG_STEP_GAIN, 32'h7fff_ffff);
          write_reg(REG_OUT_UPPER, 32'h7fff_ffff);
          write_reg(REG_OUT_LOWER, 32'h8000_0000);
        end
        2: begin
          write_reg(REG_SETPOINT, 32'h8000_0000);
          write_reg(REG_RATE_PROP, 32'h7fff_ffff);
          write_reg(REG_RATE_INTEG, 32'h7fff_ffff);
          write_reg(REG_RATE_DERIV, 32'h7fff_ffff);
          write_reg(REG_DEAD_BAND, 32'h0000_8000);
        end
        3: begin
          write_reg(REG_SETPOINT, 32'hfff0_0000);
          write_reg(REG_RATE_PROP, 32'd0);
          write_reg(REG_RATE_INTEG, 32'd0);
          write_reg(REG_RATE_DERIV, 32'd0);
          write_reg(REG_STEP_GAIN, 32'd0);
        end
        4: begin
          write_reg(REG_SETPOINT, $urandom);
          write_reg(REG_DEAD_BAND, $urandom_range(200000));
          write_reg(REG_STEP_GAIN, $urandom_range(300000));
          write_reg(REG_RATE_PROP, $urandom_range(65536));
          write_reg(REG_RATE_INTEG, $urandom_range(65536));
          write_reg(REG_RATE_DERIV, $urandom_range(65536));
          write_reg(REG_OUT_UPPER, 32'h0100_0000);
          write_reg(REG_OUT_LOWER, 32'hff00_0000);
        end
        5: begin
          write_reg(REG_OUT_UPPER, 32'h0000_1000);
          write_reg(REG_OUT_LOWER, 32'h0000_1000);
        end
        6: begin
          write_reg(REG_OUT_UPPER, 32'hffff_0000);
          write_reg(REG_OUT_LOWER, 32'h0001_0000);
        end
        default: begin
          write_reg(REG_SETPOINT, $urandom);
          write_reg(REG_DEAD_BAND, $urandom_range(1) ? 32'd0 : 32'($urandom_range(500000)));
          write_reg(REG_STEP_GAIN, $urandom);
          write_reg(REG_RATE_PROP, $urandom);
          write_reg(REG_RATE_INTEG, $urandom);
          write_reg(REG_RATE_DERIV, $urandom);
          write_reg(REG_OUT_UPPER, 32'h7fff_0000);
          write_reg(REG_OUT_LOWER, $urandom_range(1) ? 32'h0 : 32'h8000_0000);
        end
      endcase
      for (int n = 0; n < 125; n++) begin
        if (phase == 7 && n == 10) hold_req = 1'b1;
        send_measure(pick_measure());
      end
      settle_and_pause();
    end

    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("single_neuron_adaptive_pid_core regression: pass");
    end else begin
      $display("single_neuron_adaptive_pid_core regression: fail");
    end
    $finish;
  end
endmodule
